// ----- rtl/vtc_pkg.sv -----
// Shared types, codes and constants of the voxel terrain column renderer.
`timescale 1ns / 1ps

package vtc_pkg;

    // Fixed field widths
    localparam int REQ_W    = 2;
    localparam int COORD_W  = 8;
    localparam int HGT_W    = 8;
    localparam int COL_W    = 6;
    localparam int CROW_W   = 5;
    localparam int COLOR_W  = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int EYE_W    = 9;

    // Parameter defaults
    localparam int DEF_MAP_BITS    = 8;
    localparam int DEF_DEPTH_STEPS = 150;
    localparam int DEF_COLUMNS     = 40;
    localparam int DEF_ROWS        = 30;

    // Eye smoothing: (9*eye + flight + h) / 10 by reciprocal multiply
    localparam int SUM_W       = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD10_W    = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP_10 = 13'd6554;

    localparam logic [COLOR_W-1:0] SKY_COLOR  = 4'd15;
    localparam logic [CFG_W-1:0]   LOOK_RESET = 8'd5;
    localparam logic [CFG_W-1:0]   FLIGHT_RESET = 8'd0;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_FRAME  = 2'd1,
        REQ_COLUMN = 2'd2
    } t_req;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK   = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic map_we;      // write one map height from the input word
        logic load_frame;  // latch viewer position
        logic load_col;    // latch column, clear row and depth
        logic rd_frame;    // read the look-ahead map entry
        logic upd_eye;     // smooth eye height from the read data
        logic prime;       // first read of a march, at depth zero
        logic rd_next;     // read ahead at depth + 1
        logic adv_depth;   // ray missed: next depth
        logic emit;        // load one cell into the output register
        logic emit_fill;   // that cell is sky
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic depth_last;
        logic row_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/voxel_terrain_column_raycast.sv -----
// Top level of the voxel terrain column renderer.
// Input channel (i_in_valid / o_in_ready) takes one word per request:
//   write map height: stored, no result.
//   start frame: latches the viewer, reads the map entry look_ahead rows
//   ahead and smooths the eye height (read, then update state); no result.
//   render column: ROWS cells, bottom row first, on the output channel
//   (o_out_valid / i_out_ready); a column outside the screen or an unknown
//   request type is dropped with no result.
// A column passes through the prime state, then marches depth by depth
// and row by row, then fills any rows left as sky. The march issues one
// map read per cycle, always one depth ahead; hits reuse the held height.
// When the bottom row hits at once, the first cell is loaded into the
// output register from the prime read in the first march state.
// One request is in work at a time; the next is taken once the column's last
// cell sits in the output register.
// A stalled receiver holds the output register and pauses the march on its
// next hit; misses keep marching.
// Reset clears eye height, viewer position and control state, sets flight to
// 0 and look-ahead to 5. The height map keeps its contents, needs no clearing.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; write it idle.
`timescale 1ns / 1ps

module voxel_terrain_column_raycast #(
    parameter int MAP_BITS    = vtc_pkg::DEF_MAP_BITS,
    parameter int DEPTH_STEPS = vtc_pkg::DEF_DEPTH_STEPS,
    parameter int COLUMNS     = vtc_pkg::DEF_COLUMNS,
    parameter int ROWS        = vtc_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [vtc_pkg::REQ_W-1:0]       i_req_type,
    input  logic [vtc_pkg::COORD_W-1:0]     i_map_x,
    input  logic [vtc_pkg::COORD_W-1:0]     i_map_y,
    input  logic [vtc_pkg::HGT_W-1:0]       i_height_value,
    input  logic [vtc_pkg::COORD_W-1:0]     i_view_x,
    input  logic [vtc_pkg::COORD_W-1:0]     i_view_y,
    input  logic [vtc_pkg::COL_W-1:0]       i_column,
    // cell channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [vtc_pkg::COL_W-1:0]       o_out_column,
    output logic [vtc_pkg::CROW_W-1:0]      o_cell_row,
    output logic [vtc_pkg::COLOR_W-1:0]     o_color,
    output logic                            o_last_cell,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vtc_pkg::CFG_W-1:0]       i_cfg_data
);

    vtc_pkg::t_cmd cmd;
    vtc_pkg::t_sts sts;
    logic          in_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = in_ready;

    vtc_ctrl #(
        .COLUMNS (COLUMNS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_column   (i_column),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    vtc_dpath #(
        .MAP_BITS    (MAP_BITS),
        .DEPTH_STEPS (DEPTH_STEPS),
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_map_x        (i_map_x),
        .i_map_y        (i_map_y),
        .i_height_value (i_height_value),
        .i_view_x       (i_view_x),
        .i_view_y       (i_view_y),
        .i_column       (i_column),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_column   (o_out_column),
        .o_cell_row     (o_cell_row),
        .o_color        (o_color),
        .o_last_cell    (o_last_cell)
    );

endmodule

// ----- rtl/vtc_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module vtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/vtc_ctrl.sv -----
// Controller: sequences map writes, frame starts and column marches.
`timescale 1ns / 1ps

module vtc_ctrl #(
    parameter int COLUMNS = vtc_pkg::DEF_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [vtc_pkg::REQ_W-1:0]   i_req_type,
    input  logic [vtc_pkg::COL_W-1:0]   i_column,
    input  vtc_pkg::t_sts               i_sts,
    output logic                        o_in_ready,
    output vtc_pkg::t_cmd               o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME_RD,
        ST_FRAME_UPD,
        ST_PRIME,
        ST_MARCH,
        ST_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   col_ok;

    assign col_ok     = int'(i_column) < COLUMNS;
    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        vtc_pkg::REQ_WRITE: begin
                            o_cmd.map_we = 1'b1;
                        end
                        vtc_pkg::REQ_FRAME: begin
                            o_cmd.load_frame = 1'b1;
                            n_state = ST_FRAME_RD;
                        end
                        vtc_pkg::REQ_COLUMN: begin
                            if (col_ok) begin
                                o_cmd.load_col = 1'b1;
                                n_state = ST_PRIME;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FRAME_RD: begin
                o_cmd.rd_frame = 1'b1;
                n_state = ST_FRAME_UPD;
            end
            ST_FRAME_UPD: begin
                o_cmd.upd_eye = 1'b1;
                n_state = ST_IDLE;
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state = ST_MARCH;
            end
            ST_MARCH: begin
                o_cmd.rd_next = 1'b1;
                if (i_sts.hit) begin
                    // terrain above the ray: one cell, next row
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (i_sts.row_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    o_cmd.adv_depth = 1'b1;
                    if (i_sts.depth_last) begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_fill = 1'b1;
                    if (i_sts.row_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/vtc_dpath.sv -----
// Datapath: height map, viewer state, ray arithmetic and output register.
`timescale 1ns / 1ps

module vtc_dpath #(
    parameter int MAP_BITS    = vtc_pkg::DEF_MAP_BITS,
    parameter int DEPTH_STEPS = vtc_pkg::DEF_DEPTH_STEPS,
    parameter int COLUMNS     = vtc_pkg::DEF_COLUMNS,
    parameter int ROWS        = vtc_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input word
    input  logic [vtc_pkg::COORD_W-1:0]     i_map_x,
    input  logic [vtc_pkg::COORD_W-1:0]     i_map_y,
    input  logic [vtc_pkg::HGT_W-1:0]       i_height_value,
    input  logic [vtc_pkg::COORD_W-1:0]     i_view_x,
    input  logic [vtc_pkg::COORD_W-1:0]     i_view_y,
    input  logic [vtc_pkg::COL_W-1:0]       i_column,
    // configuration writes
    input  logic                            i_cfg_valid,
    input  logic [vtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vtc_pkg::CFG_W-1:0]       i_cfg_data,
    // controller
    input  vtc_pkg::t_cmd                   i_cmd,
    output vtc_pkg::t_sts                   o_sts,
    // result word
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [vtc_pkg::COL_W-1:0]       o_out_column,
    output logic [vtc_pkg::CROW_W-1:0]      o_cell_row,
    output logic [vtc_pkg::COLOR_W-1:0]     o_color,
    output logic                            o_last_cell
);

    localparam int ADDR_W = 2 * MAP_BITS;
    localparam int DEP_W  = $clog2(DEPTH_STEPS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int CLG_C  = $clog2(COLUMNS);
    localparam int XS_W   = ((CLG_C > vtc_pkg::COL_W) ? CLG_C : vtc_pkg::COL_W) + 1;
    localparam int XP_W   = XS_W + DEP_W + 1;
    localparam int RP_W   = ROW_W + DEP_W + 2;
    localparam int RAY_W  = ((RP_W > vtc_pkg::EYE_W) ? RP_W : vtc_pkg::EYE_W) + 2;

    // Configuration and viewer state
    logic [vtc_pkg::CFG_W-1:0]   r_flight;
    logic [vtc_pkg::CFG_W-1:0]   r_look;
    logic [vtc_pkg::EYE_W-1:0]   r_eye;
    logic [MAP_BITS-1:0]         r_vx;
    logic [MAP_BITS-1:0]         r_vy;

    // March state
    logic [vtc_pkg::COL_W-1:0]   r_col;
    logic [ROW_W-1:0]            r_row;
    logic [DEP_W-1:0]            r_depth;
    logic                        r_fresh;
    logic [vtc_pkg::HGT_W-1:0]   r_th;

    // Output register
    logic                        r_out_valid;
    logic [vtc_pkg::COL_W-1:0]   r_out_col;
    logic [vtc_pkg::CROW_W-1:0]  r_out_row;
    logic [vtc_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_last;

    logic [vtc_pkg::HGT_W-1:0]   ram_q;
    logic [vtc_pkg::HGT_W-1:0]   cur_h;
    logic [ADDR_W-1:0]           ram_addr;
    logic [DEP_W-1:0]            rd_depth;
    logic signed [XS_W-1:0]      xs;
    logic signed [XP_W-1:0]      xprod;
    logic signed [XP_W-1:0]      xoff;
    logic [MAP_BITS-1:0]         tx;
    logic [MAP_BITS-1:0]         ty;
    logic signed [ROW_W:0]       rowoff;
    logic signed [RP_W-1:0]      rprod;
    logic signed [RP_W-1:0]      roff;
    logic signed [RAY_W-1:0]     ray;
    logic signed [RAY_W-1:0]     hgt_s;
    logic                        row_last;
    logic                        out_free;
    logic [vtc_pkg::SUM_W-1:0]   eye_sum;
    logic [vtc_pkg::PROD10_W-1:0] eye_prod;

    // Map read address for the look-ahead depth of the march
    assign rd_depth = i_cmd.rd_next ? r_depth + DEP_W'(1) : r_depth;
    assign xs       = signed'(XS_W'(r_col)) - signed'(XS_W'(COLUMNS / 2));
    assign xprod    = xs * signed'({1'b0, rd_depth});
    assign xoff     = xprod[XP_W-1] ? (xprod + XP_W'(7)) >>> 3 : xprod >>> 3;
    assign tx       = r_vx + MAP_BITS'(xoff);
    assign ty       = r_vy + MAP_BITS'(rd_depth);

    always_comb begin
        if (i_cmd.map_we) begin
            ram_addr = {MAP_BITS'(i_map_x), MAP_BITS'(i_map_y)};
        end else if (i_cmd.rd_frame) begin
            ram_addr = {r_vx, r_vy + MAP_BITS'(r_look)};
        end else begin
            ram_addr = {tx, ty};
        end
    end

    vtc_ram #(
        .WIDTH (vtc_pkg::HGT_W),
        .DEPTH (1 << ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.map_we),
        .i_addr  (ram_addr),
        .i_wdata (i_height_value),
        .o_rdata (ram_q)
    );

    // Height at the current depth: fresh read after the prime or a depth step, else held
    assign cur_h = r_fresh ? ram_q : r_th;

    // Ray height and hit test
    assign rowoff = signed'({1'b0, r_row}) - signed'((ROW_W + 1)'(ROWS / 2));
    assign rprod  = rowoff * signed'({1'b0, r_depth});
    assign roff   = rprod[RP_W-1] ? (rprod + RP_W'(7)) >>> 3 : rprod >>> 3;
    assign ray    = signed'(RAY_W'({1'b0, r_eye})) + RAY_W'(roff);
    assign hgt_s  = signed'(RAY_W'({1'b0, cur_h}));

    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.hit        = hgt_s > ray;
    assign o_sts.depth_last = (r_depth == DEP_W'(DEPTH_STEPS - 1));
    assign o_sts.row_last   = row_last;
    assign o_sts.out_free   = out_free;

    // Eye smoothing, divide by ten via reciprocal
    assign eye_sum  = (vtc_pkg::SUM_W'(r_eye) << 3) + vtc_pkg::SUM_W'(r_eye)
                    + vtc_pkg::SUM_W'(r_flight) + vtc_pkg::SUM_W'(ram_q);
    assign eye_prod = vtc_pkg::PROD10_W'(eye_sum) * vtc_pkg::PROD10_W'(vtc_pkg::RECIP_10);

    // Control-bearing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight    <= vtc_pkg::FLIGHT_RESET;
            r_look      <= vtc_pkg::LOOK_RESET;
            r_eye       <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_out_valid <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vtc_pkg::CFG_FLIGHT: r_flight <= i_cfg_data;
                    vtc_pkg::CFG_LOOK:   r_look   <= i_cfg_data;
                    default:             r_look   <= r_look;
                endcase
            end
            if (i_cmd.load_frame) begin
                r_vx <= MAP_BITS'(i_view_x);
                r_vy <= MAP_BITS'(i_view_y);
            end
            if (i_cmd.upd_eye) begin
                r_eye <= eye_prod[vtc_pkg::RECIP_SHIFT +: vtc_pkg::EYE_W];
            end
            r_fresh <= i_cmd.prime || i_cmd.adv_depth;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // March counters and payload
    always_ff @(posedge i_clk) begin
        r_th <= cur_h;
        if (i_cmd.load_col) begin
            r_col   <= i_column;
            r_row   <= '0;
            r_depth <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.adv_depth) begin
                r_depth <= r_depth + DEP_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_out_col   <= r_col;
            r_out_row   <= vtc_pkg::CROW_W'(r_row);
            r_out_color <= i_cmd.emit_fill ? vtc_pkg::SKY_COLOR
                         : cur_h[vtc_pkg::HGT_W-1 -: vtc_pkg::COLOR_W] + vtc_pkg::COLOR_W'(1);
            r_out_last  <= row_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_cell_row   = r_out_row;
    assign o_color      = r_out_color;
    assign o_last_cell  = r_out_last;

endmodule

// ----- rtl/vtc_checker.sv -----
// Port-level checks of the column renderer, bound to the top level.
`timescale 1ns / 1ps

module vtc_checker #(
    parameter int COLUMNS = vtc_pkg::DEF_COLUMNS,
    parameter int ROWS    = vtc_pkg::DEF_ROWS
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [vtc_pkg::COL_W-1:0]       o_out_column,
    input logic [vtc_pkg::CROW_W-1:0]      o_cell_row,
    input logic [vtc_pkg::COLOR_W-1:0]     o_color,
    input logic                            o_last_cell
);

    // A stalled cell word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_column) && $stable(o_cell_row)
            && $stable(o_color) && $stable(o_last_cell))
        else $error("cell word changed while stalled");

    // The last flag marks exactly the top row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_cell == (o_cell_row == vtc_pkg::CROW_W'(ROWS - 1))))
        else $error("last flag does not match top row");

    // Only on-screen columns produce cells
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_column) < COLUMNS))
        else $error("cell for an off-screen column");

    // No new request is taken while a column is still unfinished
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_cell |-> !o_in_ready)
        else $error("request taken in the middle of a column");

endmodule

bind voxel_terrain_column_raycast vtc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_vtc_checker (.*);
